// ----- rtl/core/fpba_pkg.sv -----
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and field widths of the fit-policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  // Field widths of the channel payloads
  localparam int unsigned OP_W      = 1;
  localparam int unsigned BLK_W     = 4;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;

  // Default sizing of the free-size table
  localparam int unsigned NUM_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

  // Fit policy codes (the unused code behaves as first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  // Reset value of blocks_in_use
  localparam logic [CFG_DAT_W-1:0] BIU_RESET = 5'd16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // write one table entry from the input beat
    logic start;   // capture request and scan length, clear search
    logic scan;    // read entry at scan counter, advance counter
    logic commit;  // write back chosen entry and fill output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lim_zero;   // scan length of the new request is zero
    logic scan_last;  // scan counter sits on the last entry
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/fpba_in_if.sv -----
// ----------------------------------------------------------------------------
// fpba_in_if
// Input item channel: load or allocate beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_in_if;
  logic                           valid;
  logic                           ready;
  logic [fpba_pkg::OP_W-1:0]      operation;
  logic [fpba_pkg::BLK_W-1:0]     block_index;
  logic [fpba_pkg::SIZE_W-1:0]    size_value;

  modport source (output valid, output operation, output block_index,
                  output size_value, input ready);
  modport sink   (input valid, input operation, input block_index,
                  input size_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fpba_out_if.sv -----
// ----------------------------------------------------------------------------
// fpba_out_if
// Result channel: grant, chosen block and remaining size.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_out_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [fpba_pkg::BLK_W-1:0]     chosen_block;
  logic [fpba_pkg::SIZE_W-1:0]    remaining_size;

  modport source (output valid, output granted, output chosen_block,
                  output remaining_size, input ready);
  modport sink   (input valid, input granted, input chosen_block,
                  input remaining_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fpba_cfg_if.sv -----
// ----------------------------------------------------------------------------
// fpba_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fpba_pkg::CFG_IDX_W-1:0]   wr_index;
  logic [fpba_pkg::CFG_DAT_W-1:0]   wr_data;

  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fit_policy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-size table with first, best and worst fit allocation.
//
//   channel    dir   handshake      payload
//   alloc_in   in    valid/ready    operation, block_index, size_value
//   alloc_out  out   valid/ready    granted, chosen_block, remaining_size
//   cfg        in    valid/ready    wr_index, wr_data (ready always high)
//
// A load beat writes one table entry. An allocate beat scans N entries, N
// being blocks_in_use saturated to NUM_BLOCKS, through one read port at one
// entry per cycle; a drain state compares the last entry read and a write
// state writes back. Reset clears the table through per-entry valid bits;
// no clearing pass follows. A stalled result holds the write-back until the
// output register frees, and the input waits meanwhile; loads and a new
// scan still run while a finished result sits unread.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator #(
  parameter int unsigned NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  fpba_in_if.sink    alloc_in,
  fpba_out_if.source alloc_out,
  fpba_cfg_if.sink   cfg
);

  fpba_pkg::cmd_t  cmd;
  fpba_pkg::stat_t stat;

  // Configuration is always taken
  assign cfg.ready = 1'b1;

  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (alloc_in.valid),
    .in_op    (alloc_in.operation),
    .in_ready (alloc_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fpba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.wr_index),
    .cfg_data    (cfg.wr_data),
    .in_block    (alloc_in.block_index),
    .in_size     (alloc_in.size_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (alloc_out.valid),
    .out_ready   (alloc_out.ready),
    .out_granted (alloc_out.granted),
    .out_block   (alloc_out.chosen_block),
    .out_size    (alloc_out.remaining_size)
  );

endmodule

`default_nettype wire

// ----- rtl/core/fpba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer of the allocator: accepts beats, runs the table scan and
// schedules the write-back of each allocate request.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [fpba_pkg::OP_W-1:0]   in_op,
  output logic                             in_ready,
  input  wire fpba_pkg::stat_t             stat,
  output fpba_pkg::cmd_t                   cmd
);

  fpba_pkg::state_t state;
  fpba_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      fpba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == fpba_pkg::OP_ALLOC) begin
            cmd.start  = 1'b1;
            state_next = stat.lim_zero ? fpba_pkg::ST_WRITE : fpba_pkg::ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      fpba_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = fpba_pkg::ST_DRAIN;
        end
      end
      fpba_pkg::ST_DRAIN: begin
        // last read entry is compared in this cycle
        state_next = fpba_pkg::ST_WRITE;
      end
      fpba_pkg::ST_WRITE: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = fpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/fpba_dp.sv -----
// ----------------------------------------------------------------------------
// fpba_dp
// Datapath of the allocator: configuration registers, free-size table,
// scan counter, fit comparator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_dp #(
  parameter int unsigned NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fpba_pkg::CFG_DAT_W-1:0]   cfg_data,
  // input payload
  input  wire logic [fpba_pkg::BLK_W-1:0]       in_block,
  input  wire logic [fpba_pkg::SIZE_W-1:0]      in_size,
  // control
  input  wire fpba_pkg::cmd_t                   cmd,
  output fpba_pkg::stat_t                       stat,
  // result
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_granted,
  output logic [fpba_pkg::BLK_W-1:0]            out_block,
  output logic [fpba_pkg::SIZE_W-1:0]           out_size
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

  // Configuration registers
  logic [1:0]                      policy;
  logic [fpba_pkg::CFG_DAT_W-1:0]  biu;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= fpba_pkg::POL_FIRST;
      biu    <= fpba_pkg::BIU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::CFG_FIT_POLICY:    policy <= cfg_data[1:0];
        fpba_pkg::CFG_BLOCKS_IN_USE: biu    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input size reduced to table width
  logic [SIZE_BITS+fpba_pkg::SIZE_W-1:0] in_size_ext;
  logic [SIZE_BITS-1:0]                  in_size_tw;
  assign in_size_ext = {{SIZE_BITS{1'b0}}, in_size};
  assign in_size_tw  = in_size_ext[SIZE_BITS-1:0];

  // Scan length saturated to the table depth
  logic [CNT_W-1:0] lim_new;
  assign lim_new = (32'(biu) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu);

  // Request registers and scan counter
  logic [SIZE_BITS-1:0] req;
  logic [CNT_W-1:0]     lim;
  logic [IDX_W-1:0]     cnt;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 cmp_en;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= in_size_tw;
      lim <= lim_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.scan) begin
        cnt <= cnt + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= cnt;
    end
  end

  // Free-size table with per-entry valid bits (unwritten entries read zero)
  logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vbit;
  logic [SIZE_BITS-1:0]  rd_data;
  logic                  rd_vld;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_BITS-1:0]  wr_data;
  logic                  load_ok;

  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic [SIZE_BITS-1:0]  best;
  logic [SIZE_BITS-1:0]  rem;

  assign load_ok = cmd.load && (32'(in_block) < NUM_BLOCKS);
  assign rem     = best - req;
  assign wr_en   = load_ok || (cmd.commit && found);
  assign wr_addr = cmd.commit ? pick : IDX_W'(in_block);
  assign wr_data = cmd.commit ? rem : in_size_tw;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan) begin
      rd_data <= mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit   <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vbit[wr_addr] <= 1'b1;
      end
      if (cmd.scan) begin
        rd_vld <= vbit[cnt];
      end
    end
  end

  // Fit comparison on the entry read last cycle
  logic [SIZE_BITS-1:0] ent;
  logic                 fits;
  logic                 take;
  assign ent  = rd_vld ? rd_data : '0;
  assign fits = ent >= req;

  always_comb begin
    take = 1'b0;
    if (cmp_en && fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (policy == fpba_pkg::POL_BEST) begin
        take = ent < best;
      end else if (policy == fpba_pkg::POL_WORST) begin
        take = ent > best;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick <= cmp_idx;
      best <= ent;
    end
  end

  // Output register
  logic [SIZE_BITS+fpba_pkg::SIZE_W-1:0] rem_ext;
  assign rem_ext = {{fpba_pkg::SIZE_W{1'b0}}, rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted <= found;
      out_block   <= found ? fpba_pkg::BLK_W'(pick) : '0;
      out_size    <= found ? rem_ext[fpba_pkg::SIZE_W-1:0] : '0;
    end
  end

  // Status to the controller
  assign stat.lim_zero  = (lim_new == '0);
  assign stat.scan_last = (CNT_W'(cnt) == (lim - CNT_W'(1)));
  assign stat.out_free  = !out_valid || out_ready;

  // Checks
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while a result is still pending");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (out_valid && (out_granted == $past(found))))
    else $error("committed result not in output register");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (CNT_W'(cnt) < lim))
    else $error("scan past the configured length");

  a_pick_range: assert property (@(posedge clk) disable iff (rst)
    (found && !cmd.start) |-> (CNT_W'(pick) < lim))
    else $error("chosen block outside the scanned range");

endmodule

`default_nettype wire
